@@ rtl/core/xcfd_pkg.sv @@
package xcfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Reset values of the sync byte registers
  localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'h55;

  // Trailer bytes
  localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 1'b1;

  // Parser phases
  typedef enum logic [2:0] {
    PH_H1   = 3'd0,
    PH_H2   = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CHK  = 3'd4,
    PH_CR   = 3'd5,
    PH_LF   = 3'd6
  } phase_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    EV_BYTE    = 2'd0,
    EV_ACCEPT  = 2'd1,
    EV_DISCARD = 2'd2
  } event_kind_t;

  // One result produced by the parser for the current byte
  typedef struct packed {
    logic              valid;
    event_kind_t       kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] len;
  } xcfd_result_t;

endpackage

@@ rtl/core/xcfd_stream_if.sv @@
// Received byte channel
interface xcfd_in_if import xcfd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Frame event channel
interface xcfd_out_if import xcfd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] byte_index;
  logic [BYTE_W-1:0] frame_length;

  modport source (output valid, output event_kind, output data_byte, output byte_index,
                  output frame_length, input ready);
  modport sink   (input valid, input event_kind, input data_byte, input byte_index,
                  input frame_length, output ready);
endinterface

@@ rtl/core/xcfd_parser.sv @@
// Frame parser: holds the parse state and decodes one byte per step.
module xcfd_parser import xcfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] first_hdr,
  input  logic [BYTE_W-1:0] second_hdr,
  output xcfd_result_t      res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] check_r, check_nxt;
  logic [BYTE_W-1:0] count_inc;

  assign count_inc = count_r + 8'd1;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_H1;
      len_r   <= '0;
      count_r <= '0;
      check_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      check_r <= check_nxt;
    end
  end

  // Next state and result decode
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    check_nxt = check_r;
    res.valid = 1'b0;
    res.kind  = EV_BYTE;
    res.data  = '0;
    res.idx   = '0;
    res.len   = len_r;
    unique case (phase_r)
      PH_H2: begin
        phase_nxt = (rx_byte == second_hdr) ? PH_LEN : PH_H1;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        count_nxt = '0;
        check_nxt = rx_byte;
        phase_nxt = (rx_byte != '0) ? PH_DATA : PH_H1;
      end
      PH_DATA: begin
        count_nxt = count_inc;
        check_nxt = check_r ^ rx_byte;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CHK;
        end
        res.valid = 1'b1;
        res.kind  = EV_BYTE;
        res.data  = rx_byte;
        res.idx   = count_r;
      end
      PH_CHK: begin
        if (rx_byte == check_r) begin
          phase_nxt = PH_CR;
        end else begin
          phase_nxt = PH_H1;
          res.valid = 1'b1;
          res.kind  = EV_DISCARD;
        end
      end
      PH_CR: begin
        if (rx_byte == CR_BYTE) begin
          phase_nxt = PH_LF;
        end else begin
          phase_nxt = PH_H1;
          res.valid = 1'b1;
          res.kind  = EV_DISCARD;
        end
      end
      PH_LF: begin
        phase_nxt = PH_H1;
        res.valid = 1'b1;
        res.kind  = (rx_byte == LF_BYTE) ? EV_ACCEPT : EV_DISCARD;
      end
      default: begin
        // header search, also the unused phase code
        phase_nxt = (rx_byte == first_hdr) ? PH_H2 : PH_H1;
      end
    endcase
  end

  // A length byte of zero drops back to the header search
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_LEN && rx_byte == '0 |=> phase_r == PH_H1)
    else $error("zero length did not return to header search");

  // Results come only from the payload and trailer phases
  a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (phase_r == PH_DATA || phase_r == PH_CHK ||
                   phase_r == PH_CR || phase_r == PH_LF))
    else $error("result outside payload or trailer");

  // Payload index stays below the declared length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == EV_BYTE |-> count_r < len_r)
    else $error("payload index beyond declared length");

  // Last payload byte moves to the check byte
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_DATA && count_inc == len_r |=> phase_r == PH_CHK)
    else $error("last payload byte did not move to check phase");

endmodule

@@ rtl/core/xor_checked_frame_deframer.sv @@
// Length-prefixed frame deframer with XOR check byte. Takes one received byte
// per beat and finds frames of two sync bytes, a length byte L, L payload
// bytes, a check byte (XOR of the length and payload bytes), CR and LF. Each
// payload byte leaves as an event with its index; after the trailer, or at a
// bad check or CR byte, an accept or discard event tells the consumer to commit
// or drop the payload. A frame broken before its payload starts produces no
// event. One byte is taken every clock cycle while input is not held back; a
// byte sits in an input register while the parser decodes it, and its event is
// then loaded into the output register, from which the consumer takes it. Input
// is held back only when the output register is full, is not being drained,
// and the waiting byte would produce an event. Sync byte values are set through
// the cfg port (index 0 first, 1 second) and should only be changed while the
// block is idle.
module xor_checked_frame_deframer import xcfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  xcfd_in_if.sink              in_ch,
  xcfd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BYTE_W-1:0] first_hdr_r;
  logic [BYTE_W-1:0] second_hdr_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_data_r;
  logic [BYTE_W-1:0] out_idx_r;
  logic [BYTE_W-1:0] out_len_r;
  logic              out_free;
  logic              step;
  logic              in_beat;
  xcfd_result_t      res;

  // Sync byte registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= FIRST_HDR_RST;
      second_hdr_r <= SECOND_HDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIRST_HDR:  first_hdr_r  <= cfg_wdata;
        CFG_SECOND_HDR: second_hdr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Flow control: parse a byte when it yields no event or its event has somewhere to go
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && (!res.valid || out_free);
  assign in_ch.ready = !s1_valid_r || step;
  assign in_beat     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  xcfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (s1_byte_r),
    .first_hdr  (first_hdr_r),
    .second_hdr (second_hdr_r),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_idx_r  <= res.idx;
      out_len_r  <= res.len;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.data_byte    = out_data_r;
  assign out_ch.byte_index   = out_idx_r;
  assign out_ch.frame_length = out_len_r;

  // A pending event is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid |-> out_free)
    else $error("output register overwritten");

  // A parsed byte that yields an event shows up in the output register
  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid |=> out_valid_r)
    else $error("event lost");

  // A held byte waits only on a full, stalled output register
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step |-> out_valid_r && !out_ch.ready)
    else $error("input register stalled without cause");

endmodule
